// ===== src/bgrpal_pkg.sv =====
// ----------------------------------------------------------------------------
// bgrpal_pkg
// Shared constants, codes and a helper function for the BGR555 palette lookup
// stage with master brightness.
// ----------------------------------------------------------------------------
`default_nettype none

package bgrpal_pkg;

   // Palette geometry.
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int WORD_W                = 15;
   localparam int INDEX_W               = 8;

   // Colour channel geometry.
   localparam int CHAN_W   = 5;
   localparam int COLOR_W  = 8;
   localparam int LEVEL_W  = 4;
   localparam int PROD_W   = COLOR_W + LEVEL_W;
   localparam int CFG_W    = 8;

   // Brightness saturates at full scale.
   localparam int LEVEL_MAX = 15;

   // Division by fifteen as a reciprocal multiply: for products below 4096,
   // floor(x * 4370 / 65536) equals floor(x / 15).
   localparam int RECIP       = 4370;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = PROD_W + 13;

   // Item function codes.
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Register indexes.
   localparam logic CSR_BRIGHTNESS = 1'b0;
   localparam logic CSR_LAST_ENTRY = 1'b1;

   // Widen a 5-bit channel to 8 bits by repeating its top bits.
   function automatic logic [COLOR_W-1:0] widen5(input logic [CHAN_W-1:0] c5);
      widen5 = {c5, c5[CHAN_W-1 -: 3]};
   endfunction

endpackage

`default_nettype wire

// ===== src/bgrpal_ram.sv =====
// ----------------------------------------------------------------------------
// bgrpal_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrpal_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bgrpal_scale.sv =====
// ----------------------------------------------------------------------------
// bgrpal_scale
// Two-stage colour scaler: widens the three BGR555 channels, multiplies each
// by the brightness level, then divides by fifteen into the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrpal_scale
   import bgrpal_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic [LEVEL_W-1:0] level,
   input  wire logic [WORD_W-1:0]  entry,
   output logic      [COLOR_W-1:0] red,
   output logic      [COLOR_W-1:0] green,
   output logic      [COLOR_W-1:0] blue
);

   logic [PROD_W-1:0]  prod_in  [3];
   logic [PROD_W-1:0]  prod_ff  [3];
   logic [RECIP_W-1:0] recip    [3];
   logic [COLOR_W-1:0] color_in [3];
   logic [COLOR_W-1:0] color_ff [3];

   // Widen each channel and scale it by the level.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod_in[ch] = PROD_W'(widen5(entry[ch*CHAN_W +: CHAN_W])) * PROD_W'(level);
      end
   end

   // Divide each product by fifteen through the reciprocal.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         recip[ch]    = RECIP_W'(prod_ff[ch]) * RECIP_W'(RECIP);
         color_in[ch] = recip[ch][RECIP_SHIFT +: COLOR_W];
      end
   end

   // Product and result registers advance together with the pipeline.
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= prod_in;
         color_ff <= color_in;
      end
   end

   assign red   = color_ff[0];
   assign green = color_ff[1];
   assign blue  = color_ff[2];

endmodule

`default_nettype wire

// ===== src/bgr555_palette_lookup_brightness.sv =====
// Throughput: one item per cycle while no result is stalled; a lookup
// transfer gives a result and a write gives none.
// The palette RAM read, the brightness multiply and the divide by fifteen
// each take one pipeline stage; a stalled result freezes every stage.
// Reset clears the stage valid bits and sets brightness to 15 and the last
// entry to 255; palette contents are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
// bgr555_palette_lookup_brightness
// Palette output stage: stores BGR555 words and looks up pixels, giving RGB888
// colour scaled by a saturating master brightness.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr555_palette_lookup_brightness
   import bgrpal_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input channel.
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic [INDEX_W-1:0] req_index,
   input  wire logic [WORD_W-1:0]  req_palette_word,
   // Result channel.
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [COLOR_W-1:0] rsp_red,
   output logic      [COLOR_W-1:0] rsp_green,
   output logic      [COLOR_W-1:0] rsp_blue,
   // Configuration port.
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam logic [INDEX_W:0] DEPTH_W = (INDEX_W+1)'(PALETTE_DEPTH);
   localparam logic [INDEX_W:0] LAST_W  = (INDEX_W+1)'(PALETTE_DEPTH - 1);

   logic [CFG_W-1:0]   brightness_ff;
   logic [CFG_W-1:0]   last_entry_ff;
   logic               advance;
   logic               req_xfer;
   logic               wr_en;
   logic               rd_valid;
   logic [INDEX_W-1:0] sel_clamp;
   logic [AW-1:0]      rd_addr;
   logic [LEVEL_W-1:0] level;
   logic [WORD_W-1:0]  rd_data;
   logic               s1_valid_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic               s2_valid_ff;
   logic               rsp_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= CFG_W'(LEVEL_MAX);
         last_entry_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: brightness_ff <= csr_wdata;
            CSR_LAST_ENTRY: last_entry_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // The whole pipeline moves unless a finished result is held back.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign req_xfer  = req_valid && advance;

   // Writes beyond the palette are dropped.
   assign wr_en = req_xfer && (req_func == FUNC_WRITE)
                  && ({1'b0, req_index} < DEPTH_W);

   // Lookup address: clamp to the last entry in use, then to the palette.
   always_comb begin
      sel_clamp = (req_index < last_entry_ff) ? req_index : last_entry_ff;
      if ({1'b0, sel_clamp} > LAST_W) begin
         rd_addr = LAST_W[AW-1:0];
      end else begin
         rd_addr = sel_clamp[AW-1:0];
      end
   end

   assign rd_valid = req_xfer && (req_func == FUNC_LOOKUP);
   assign level    = (brightness_ff > CFG_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                        : brightness_ff[LEVEL_W-1:0];

   bgrpal_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_index[AW-1:0]),
      .wr_data (req_palette_word),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= rd_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // The level travels alongside the RAM read.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_level_ff <= level;
      end
   end

   bgrpal_scale u_scale (
      .clock  (clock),
      .enable (advance),
      .level  (s1_level_ff),
      .entry  (rd_data),
      .red    (rsp_red),
      .green  (rsp_green),
      .blue   (rsp_blue)
   );

   assign rsp_valid = rsp_valid_ff;

   // A lookup transfer always occupies the first stage on the next cycle.
   a_lookup_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FUNC_LOOKUP) |=> s1_valid_ff)
      else $error("lookup transfer did not enter the first stage");

   // A write transfer never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FUNC_WRITE) |=> !s1_valid_ff)
      else $error("write transfer entered the lookup pipeline");

   // A lookup in the first stage moves on whenever the result side is free.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !(rsp_valid && rsp_stall)) |=> s2_valid_ff)
      else $error("lookup lost between first and second stage");

   // A held result keeps the earlier stages frozen.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire
